FILE: hdl/iacn_pkg.sv
// iacn_pkg: shared types, constants and fixed-point helpers of the activation network engine
// used by iacn_mac and interactive_activation_network_cycle; depends on nothing
`default_nettype none
package iacn_pkg;

   localparam int NUM_UNITS   = 64;
   localparam int UNIT_BITS   = $clog2(NUM_UNITS);
   localparam int WADDR_BITS  = 2 * UNIT_BITS;
   localparam int VALUE_BITS  = 16;
   localparam int FRAC        = 12;
   localparam int SUM_BITS    = 32;
   localparam int MUL_A_BITS  = 32;
   localparam int MUL_B_BITS  = 16;
   localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
   localparam int DECAY_BITS  = 13;
   localparam int KEEP_BITS   = 14;
   localparam int CYCLE_BITS  = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int NEW_BITS    = VALUE_BITS + 3;

   localparam logic [UNIT_BITS-1:0] LAST_UNIT = UNIT_BITS'(NUM_UNITS - 1);
   localparam logic [WADDR_BITS-1:0] LAST_WADDR = '1;
   localparam logic [KEEP_BITS-1:0] ONE_Q = KEEP_BITS'(4096);

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   localparam value_type RST_EXT_STRENGTH = 16'sd410;
   localparam value_type RST_EXCITE_GAIN  = 16'sd410;
   localparam value_type RST_INHIBIT_GAIN = 16'sd410;
   localparam logic [DECAY_BITS-1:0] RST_DECAY = 13'd410;
   localparam value_type RST_REST_LEVEL   = -16'sd410;
   localparam value_type RST_MAX_ACT      = 16'sd4096;
   localparam value_type RST_MIN_ACT      = -16'sd819;

   localparam logic [CSR_IDX_BITS-1:0] CSR_EXT_STRENGTH = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXCITE_GAIN  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INHIBIT_GAIN = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DECAY_RATE   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REST_LEVEL   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ACT      = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_ACT      = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GROSSBERG    = 3'd7;

   typedef enum logic [1:0] {
      FUNC_LOAD_WEIGHT = 2'd0,
      FUNC_LOAD_EXT    = 2'd1,
      FUNC_REST        = 2'd2,
      FUNC_RUN         = 2'd3
   } func_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REST_FILL,
      ST_RUN_DRIFT,
      ST_RUN_DRIFT2,
      ST_G_INIT,
      ST_G_ISSUE,
      ST_G_DRAIN,
      ST_FIN_EX,
      ST_FIN_IN,
      ST_FIN_EXT,
      ST_FIN_WR,
      ST_ADV_RD,
      ST_ADV_A,
      ST_ADV_B,
      ST_ADV_C,
      ST_ADV_D,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctl_type;

   // product to Q4.12 with floor shift and saturation
   function automatic value_type qsat(input prod_type p);
      logic signed [PROD_BITS-FRAC-1:0] s;
      logic [PROD_BITS-FRAC-VALUE_BITS:0] hi;
      begin
         s = p[PROD_BITS-1:FRAC];
         hi = s[PROD_BITS-FRAC-1:VALUE_BITS-1];
         if ((&hi) || !(|hi)) begin
            qsat = s[VALUE_BITS-1:0];
         end else if (s[PROD_BITS-FRAC-1]) begin
            qsat = {1'b1, {(VALUE_BITS-1){1'b0}}};
         end else begin
            qsat = {1'b0, {(VALUE_BITS-1){1'b1}}};
         end
      end
   endfunction

   function automatic value_type sat_new(input logic signed [NEW_BITS-1:0] x);
      logic [NEW_BITS-VALUE_BITS:0] hi;
      begin
         hi = x[NEW_BITS-1:VALUE_BITS-1];
         if ((&hi) || !(|hi)) begin
            sat_new = x[VALUE_BITS-1:0];
         end else if (x[NEW_BITS-1]) begin
            sat_new = {1'b1, {(VALUE_BITS-1){1'b0}}};
         end else begin
            sat_new = {1'b0, {(VALUE_BITS-1){1'b1}}};
         end
      end
   endfunction

   function automatic sum_type sat_sum(input logic signed [SUM_BITS:0] x);
      begin
         if (x[SUM_BITS] == x[SUM_BITS-1]) begin
            sat_sum = x[SUM_BITS-1:0];
         end else if (x[SUM_BITS]) begin
            sat_sum = {1'b1, {(SUM_BITS-1){1'b0}}};
         end else begin
            sat_sum = {1'b0, {(SUM_BITS-1){1'b1}}};
         end
      end
   endfunction

endpackage
`default_nettype wire

FILE: hdl/interactive_activation_network_cycle.sv
// interactive_activation_network_cycle: top level of the activation network engine
// depends on iacn_pkg and iacn_mac
//
// channel   direction  handshake           payload
// req_      in         req_valid/req_stall  func, target_unit, source_unit, value, cycle_count
// rsp_      out        rsp_valid/rsp_stall  unit_index, activation, last
// csr_      in         csr_we               csr_index, csr_wdata
//
// after reset a clearing pass zeroes the weight memory; no request is taken
// loads are written at acceptance in the idle state; a rest request sets all 64 activations to the rest level
// a run makes 64 weight reads per unit through one port
// the report then gives the results one unit at a time, holding each while rsp_stall is high
// req_stall is high whenever the engine is not idle: clearing, rest fill, and a run until its last result is taken
`default_nettype none
module interactive_activation_network_cycle (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [1:0]                          req_func,
   input  wire logic [iacn_pkg::UNIT_BITS-1:0]      req_target_unit,
   input  wire logic [iacn_pkg::UNIT_BITS-1:0]      req_source_unit,
   input  wire logic signed [iacn_pkg::VALUE_BITS-1:0] req_value,
   input  wire logic [iacn_pkg::CYCLE_BITS-1:0]     req_cycle_count,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [iacn_pkg::UNIT_BITS-1:0]      rsp_unit_index,
   output      logic signed [iacn_pkg::VALUE_BITS-1:0] rsp_activation,
   output      logic                                rsp_last,
   input  wire logic                                csr_we,
   input  wire logic [iacn_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [iacn_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import iacn_pkg::*;

   state_type state_ff, state_in;
   logic [UNIT_BITS-1:0]  i_ff, i_in;
   logic [UNIT_BITS-1:0]  j_ff, j_in;
   logic [WADDR_BITS-1:0] clr_ff, clr_in;
   logic [CYCLE_BITS-1:0] cyc_ff, cyc_in;
   logic                  rd_v_ff, rd_v_in;

   value_type ext_strength_ff, excite_gain_ff, inhibit_gain_ff;
   logic [DECAY_BITS-1:0] decay_ff;
   value_type rest_ff, max_ff, min_ff;
   logic      gross_ff;

   prod_type  mul_ff, mul_in;
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   value_type ex_q_ff, ex_q_in;
   value_type in_q_ff, in_q_in;
   value_type drift_ff, drift_in;
   value_type exs_ff, exs_in;
   value_type ins_ff, ins_in;
   value_type up_ff, up_in;
   value_type down_ff, down_in;
   value_type base_ff, base_in;
   value_type t1_ff, t1_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [UNIT_BITS-1:0]  rsp_unit_ff, rsp_unit_in;
   value_type             rsp_act_ff, rsp_act_in;
   logic                  rsp_last_ff, rsp_last_in;

   value_type w_mem [2**WADDR_BITS];
   logic                  w_we;
   logic [WADDR_BITS-1:0] w_waddr, w_raddr;
   value_type             w_wdata, w_rd_ff;

   value_type act_mem [NUM_UNITS];
   logic                  act_we;
   logic [UNIT_BITS-1:0]  act_waddr, act_raddr;
   value_type             act_wdata, act_rd_ff;

   value_type ext_mem [NUM_UNITS];
   logic                  ext_we;
   logic [UNIT_BITS-1:0]  ext_waddr;
   value_type             ext_wdata, ext_rd_ff;

   logic [2*VALUE_BITS-1:0] sum_mem [NUM_UNITS];
   logic                    sum_we;
   logic [2*VALUE_BITS-1:0] sum_wdata, sum_rd_ff;

   mac_ctl_type mac_ctl;
   sum_type     ex_acc, in_acc;
   logic        mac_busy;

   logic [KEEP_BITS-1:0] keep;
   logic signed [VALUE_BITS:0] up_diff, down_diff;
   logic signed [NEW_BITS-1:0] n_sum, n_clamped, max_x, min_x;
   value_type e_q, t2, g_ex, g_in;
   logic signed [VALUE_BITS+1:0] net_sum;
   logic signed [VALUE_BITS:0]   gex_sum, gin_sum;

   iacn_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .act    (act_rd_ff),
      .weight (w_rd_ff),
      .ex_acc (ex_acc),
      .in_acc (in_acc),
      .busy   (mac_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_strength_ff <= RST_EXT_STRENGTH;
         excite_gain_ff  <= RST_EXCITE_GAIN;
         inhibit_gain_ff <= RST_INHIBIT_GAIN;
         decay_ff        <= RST_DECAY;
         rest_ff         <= RST_REST_LEVEL;
         max_ff          <= RST_MAX_ACT;
         min_ff          <= RST_MIN_ACT;
         gross_ff        <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EXT_STRENGTH: ext_strength_ff <= csr_wdata;
            CSR_EXCITE_GAIN:  excite_gain_ff  <= csr_wdata;
            CSR_INHIBIT_GAIN: inhibit_gain_ff <= csr_wdata;
            CSR_DECAY_RATE:   decay_ff        <= csr_wdata[DECAY_BITS-1:0];
            CSR_REST_LEVEL:   rest_ff         <= csr_wdata;
            CSR_MAX_ACT:      max_ff          <= csr_wdata;
            CSR_MIN_ACT:      min_ff          <= csr_wdata;
            CSR_GROSSBERG:    gross_ff        <= csr_wdata[0];
            default:          gross_ff        <= gross_ff;
         endcase
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem[w_waddr] <= w_wdata;
      end
      w_rd_ff <= w_mem[w_raddr];
      if (act_we) begin
         act_mem[act_waddr] <= act_wdata;
      end
      act_rd_ff <= act_mem[act_raddr];
      if (ext_we) begin
         ext_mem[ext_waddr] <= ext_wdata;
      end
      ext_rd_ff <= ext_mem[i_ff];
      if (sum_we) begin
         sum_mem[i_ff] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         i_ff         <= '0;
         j_ff         <= '0;
         clr_ff       <= '0;
         cyc_ff       <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         clr_ff       <= clr_in;
         cyc_ff       <= cyc_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mul_ff      <= mul_in;
      ex_q_ff     <= ex_q_in;
      in_q_ff     <= in_q_in;
      drift_ff    <= drift_in;
      exs_ff      <= exs_in;
      ins_ff      <= ins_in;
      up_ff       <= up_in;
      down_ff     <= down_in;
      base_ff     <= base_in;
      t1_ff       <= t1_in;
      rsp_unit_ff <= rsp_unit_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      keep      = ONE_Q - {1'b0, decay_ff};
      up_diff   = {max_ff[VALUE_BITS-1], max_ff} - {act_rd_ff[VALUE_BITS-1], act_rd_ff};
      down_diff = {act_rd_ff[VALUE_BITS-1], act_rd_ff} - {min_ff[VALUE_BITS-1], min_ff};
      e_q       = qsat(mul_ff);
      net_sum   = (VALUE_BITS+2)'(ex_q_ff) + (VALUE_BITS+2)'(in_q_ff) + (VALUE_BITS+2)'(e_q);
      gex_sum   = (VALUE_BITS+1)'(ex_q_ff) + (VALUE_BITS+1)'(e_q);
      gin_sum   = (VALUE_BITS+1)'(in_q_ff) + (VALUE_BITS+1)'(e_q);
      g_ex      = (ext_rd_ff > 0) ? sat_new(NEW_BITS'(gex_sum)) : ex_q_ff;
      g_in      = (ext_rd_ff < 0) ? sat_new(NEW_BITS'(gin_sum)) : in_q_ff;
      t2        = gross_ff ? qsat(mul_ff) : '0;
      n_sum     = NEW_BITS'(t1_ff) + NEW_BITS'(t2) + NEW_BITS'(base_ff) + NEW_BITS'(drift_ff);
      max_x     = NEW_BITS'(max_ff);
      min_x     = NEW_BITS'(min_ff);
      n_clamped = n_sum;
      if (gross_ff) begin
         priority if (n_sum > max_x) begin
            n_clamped = max_x;
         end else if (n_sum < min_x) begin
            n_clamped = min_x;
         end
      end else if (exs_ff > 0) begin
         if (n_sum > max_x) begin
            n_clamped = max_x;
         end
      end else begin
         if (n_sum < min_x) begin
            n_clamped = min_x;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      clr_in       = clr_ff;
      cyc_in       = cyc_ff;
      rd_v_in      = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      ex_q_in      = ex_q_ff;
      in_q_in      = in_q_ff;
      drift_in     = drift_ff;
      exs_in       = exs_ff;
      ins_in       = ins_ff;
      up_in        = up_ff;
      down_in      = down_ff;
      base_in      = base_ff;
      t1_in        = t1_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_unit_in  = rsp_unit_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_last_in  = rsp_last_ff;
      w_we         = 1'b0;
      w_waddr      = {req_target_unit, req_source_unit};
      w_wdata      = req_value;
      w_raddr      = {i_ff, j_ff};
      act_we       = 1'b0;
      act_waddr    = i_ff;
      act_wdata    = rest_ff;
      act_raddr    = (state_ff == ST_G_ISSUE) ? j_ff : i_ff;
      ext_we       = 1'b0;
      ext_waddr    = req_target_unit;
      ext_wdata    = req_value;
      sum_we       = 1'b0;
      sum_wdata    = '0;
      mac_ctl      = '{clear: 1'b0, valid: rd_v_ff};
      req_stall    = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_CLEAR: begin
            w_we    = 1'b1;
            w_waddr = clr_ff;
            w_wdata = '0;
            if (clr_ff[WADDR_BITS-1:UNIT_BITS] == '0) begin
               ext_we    = 1'b1;
               ext_waddr = clr_ff[UNIT_BITS-1:0];
               ext_wdata = '0;
               act_we    = 1'b1;
               act_waddr = clr_ff[UNIT_BITS-1:0];
               act_wdata = RST_REST_LEVEL;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_WADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            i_in = '0;
            if (req_valid) begin
               unique case (func_type'(req_func))
                  FUNC_LOAD_WEIGHT: w_we = 1'b1;
                  FUNC_LOAD_EXT:    ext_we = 1'b1;
                  FUNC_REST:        state_in = ST_REST_FILL;
                  FUNC_RUN: begin
                     cyc_in = req_cycle_count;
                     state_in = (req_cycle_count == '0) ? ST_OUT_RD : ST_RUN_DRIFT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_REST_FILL: begin
            act_we = 1'b1;
            i_in   = i_ff + 1'b1;
            if (i_ff == LAST_UNIT) begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN_DRIFT: begin
            mul_a    = MUL_A_BITS'($signed({1'b0, decay_ff}));
            mul_b    = rest_ff;
            state_in = ST_RUN_DRIFT2;
         end
         ST_RUN_DRIFT2: begin
            drift_in = qsat(mul_ff);
            i_in     = '0;
            state_in = ST_G_INIT;
         end
         ST_G_INIT: begin
            mac_ctl.clear = 1'b1;
            j_in     = '0;
            state_in = ST_G_ISSUE;
         end
         ST_G_ISSUE: begin
            rd_v_in = 1'b1;
            j_in    = j_ff + 1'b1;
            if (j_ff == LAST_UNIT) begin
               state_in = ST_G_DRAIN;
            end
         end
         ST_G_DRAIN: begin
            if (!rd_v_ff && !mac_busy) begin
               state_in = ST_FIN_EX;
            end
         end
         ST_FIN_EX: begin
            mul_a    = ex_acc;
            mul_b    = excite_gain_ff;
            state_in = ST_FIN_IN;
         end
         ST_FIN_IN: begin
            ex_q_in  = qsat(mul_ff);
            mul_a    = in_acc;
            mul_b    = inhibit_gain_ff;
            state_in = ST_FIN_EXT;
         end
         ST_FIN_EXT: begin
            in_q_in  = qsat(mul_ff);
            mul_a    = MUL_A_BITS'(ext_strength_ff);
            mul_b    = ext_rd_ff;
            state_in = ST_FIN_WR;
         end
         ST_FIN_WR: begin
            sum_we = 1'b1;
            if (gross_ff) begin
               sum_wdata = {g_ex, g_in};
            end else begin
               sum_wdata = {sat_new(NEW_BITS'(net_sum)), in_q_ff};
            end
            if (i_ff == LAST_UNIT) begin
               i_in     = '0;
               state_in = ST_ADV_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_G_INIT;
            end
         end
         ST_ADV_RD: begin
            state_in = ST_ADV_A;
         end
         ST_ADV_A: begin
            exs_in   = sum_rd_ff[2*VALUE_BITS-1:VALUE_BITS];
            ins_in   = sum_rd_ff[VALUE_BITS-1:0];
            up_in    = sat_new(NEW_BITS'(up_diff));
            down_in  = sat_new(NEW_BITS'(down_diff));
            mul_a    = MUL_A_BITS'($signed(keep));
            mul_b    = act_rd_ff;
            state_in = ST_ADV_B;
         end
         ST_ADV_B: begin
            base_in  = qsat(mul_ff);
            mul_a    = MUL_A_BITS'(exs_ff);
            mul_b    = (gross_ff || (exs_ff > 0)) ? up_ff : down_ff;
            state_in = ST_ADV_C;
         end
         ST_ADV_C: begin
            t1_in    = qsat(mul_ff);
            mul_a    = MUL_A_BITS'(ins_ff);
            mul_b    = down_ff;
            state_in = ST_ADV_D;
         end
         ST_ADV_D: begin
            act_we    = 1'b1;
            act_wdata = sat_new(n_clamped);
            if (i_ff == LAST_UNIT) begin
               i_in = '0;
               if (cyc_ff == CYCLE_BITS'(1)) begin
                  state_in = ST_OUT_RD;
               end else begin
                  cyc_in   = cyc_ff - 1'b1;
                  state_in = ST_G_INIT;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_ADV_RD;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_unit_in  = i_ff;
            rsp_act_in   = act_rd_ff;
            rsp_last_in  = (i_ff == LAST_UNIT);
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  i_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      mul_in = mul_a * mul_b;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_unit_index = rsp_unit_ff;
   assign rsp_activation = rsp_act_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
`default_nettype wire

FILE: hdl/iacn_mac.sv
// iacn_mac: multiply-accumulate pipe that gathers excitatory and inhibitory sums
// depends on iacn_pkg
`default_nettype none
module iacn_mac (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire iacn_pkg::mac_ctl_type ctl,
   input  wire iacn_pkg::value_type act,
   input  wire iacn_pkg::value_type weight,
   output      iacn_pkg::sum_type   ex_acc,
   output      iacn_pkg::sum_type   in_acc,
   output      logic                busy
);
   import iacn_pkg::*;

   logic      v_ff, v_in;
   logic      pos_ff, pos_in;
   logic      neg_ff, neg_in;
   value_type q_ff, q_in;
   sum_type   ex_ff, ex_in;
   sum_type   inh_ff, inh_in;
   prod_type  prod;
   logic signed [SUM_BITS:0] ex_sum;
   logic signed [SUM_BITS:0] in_sum;

   always_comb begin
      prod   = act * weight;
      q_in   = qsat(prod);
      v_in   = ctl.valid;
      pos_in = (act > 0) && (weight > 0);
      neg_in = (act > 0) && (weight < 0);
      ex_sum = {ex_ff[SUM_BITS-1], ex_ff} + (SUM_BITS+1)'(q_ff);
      in_sum = {inh_ff[SUM_BITS-1], inh_ff} + (SUM_BITS+1)'(q_ff);
      ex_in  = ex_ff;
      inh_in = inh_ff;
      if (ctl.clear) begin
         ex_in  = '0;
         inh_in = '0;
      end else if (v_ff && pos_ff) begin
         ex_in = sat_sum(ex_sum);
      end else if (v_ff && neg_ff) begin
         inh_in = sat_sum(in_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      pos_ff <= pos_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
      ex_ff  <= ex_in;
      inh_ff <= inh_in;
   end

   assign ex_acc = ex_ff;
   assign in_acc = inh_ff;
   assign busy   = v_ff;

endmodule
`default_nettype wire
